>>> sv/deq_pkg.sv
// shared types and codes for the double-ended queue
// no dependencies; imported by deq_ctrl, deq_mem and double_ended_queue_top
package deq_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

>>> sv/deq_mem.sv
// entry storage of the ring: one write port, one read port, registered read data
// depends on deq_pkg for the word type
module deq_mem import deq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  word_t            wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output word_t            rd_data
);

	word_t mem [DEPTH];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/deq_ctrl.sv
// command decode, ring pointers and cached end words of the deque
// depends on deq_pkg; drives the ports of deq_mem
module deq_ctrl import deq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             in_cmd,
	input  word_t            in_value,
	output logic             res_valid,
	input  logic             res_take,
	output status_t          res_status,
	output word_t            res_removed,
	output word_t            res_front,
	output word_t            res_rear,
	output logic [CNT_W-1:0] res_count,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output word_t            mem_wdata,
	output logic             mem_re,
	output logic [IDX_W-1:0] mem_raddr,
	input  word_t            mem_rdata
);

	localparam int SUM_W = CNT_W + 1;

	logic             busy_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	word_t            front_q;
	word_t            rear_q;
	logic             fix_front_s1;
	logic             fix_rear_s1;
	status_t          status_s1;
	word_t            removed_s1;

	logic             accept;
	logic             done;
	logic             full;
	logic             empty;
	word_t            front_cur;
	word_t            rear_cur;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] head_inc;
	logic [SUM_W-1:0] tail_sum;
	logic [SUM_W-1:0] last_sum;
	logic [SUM_W-1:0] tail_wrap;
	logic [SUM_W-1:0] last_wrap;

	logic [IDX_W-1:0] head_n;
	logic [CNT_W-1:0] count_n;
	word_t            front_n;
	word_t            rear_n;
	status_t          status_n;
	word_t            removed_n;
	logic             fix_front_n;
	logic             fix_rear_n;
	logic             we_n;
	logic             re_n;

	// a pop still waiting on its read data takes the end word straight from the memory
	assign front_cur = (busy_q && fix_front_s1) ? mem_rdata : front_q;
	assign rear_cur  = (busy_q && fix_rear_s1)  ? mem_rdata : rear_q;

	assign done     = busy_q && res_take;
	assign in_ready = !busy_q || res_take;
	assign accept   = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	// slot after the rear, slot before it; tail_sum stays below twice the depth
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign last_sum  = tail_sum - SUM_W'(2);
	assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
	assign last_wrap = (last_sum >= SUM_W'(DEPTH)) ? last_sum - SUM_W'(DEPTH) : last_sum;

	always_comb begin
		head_n      = head_q;
		count_n     = count_q;
		front_n     = front_cur;
		rear_n      = rear_cur;
		status_n    = ST_OK;
		removed_n   = '0;
		fix_front_n = 1'b0;
		fix_rear_n  = 1'b0;
		we_n        = 1'b0;
		re_n        = 1'b0;
		mem_waddr   = head_dec;
		mem_raddr   = head_inc;
		unique case (in_cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we_n      = 1'b1;
					mem_waddr = head_dec;
					head_n    = head_dec;
					count_n   = count_q + CNT_W'(1);
					front_n   = in_value;
					if (empty) begin
						rear_n = in_value;
					end
				end
			end
			CMD_PUSH_REAR: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we_n      = 1'b1;
					mem_waddr = tail_wrap[IDX_W-1:0];
					count_n   = count_q + CNT_W'(1);
					rear_n    = in_value;
					if (empty) begin
						front_n = in_value;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					removed_n = front_cur;
					head_n    = head_inc;
					count_n   = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						front_n = '0;
						rear_n  = '0;
					end else begin
						re_n        = 1'b1;
						mem_raddr   = head_inc;
						fix_front_n = 1'b1;
					end
				end
			end
			CMD_POP_REAR: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					removed_n = rear_cur;
					count_n   = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						front_n = '0;
						rear_n  = '0;
					end else begin
						re_n       = 1'b1;
						mem_raddr  = last_wrap[IDX_W-1:0];
						fix_rear_n = 1'b1;
					end
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	assign mem_we    = accept && we_n;
	assign mem_re    = accept && re_n;
	assign mem_wdata = in_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			head_q       <= '0;
			count_q      <= '0;
			front_q      <= '0;
			rear_q       <= '0;
			fix_front_s1 <= 1'b0;
			fix_rear_s1  <= 1'b0;
		end else if (accept) begin
			busy_q       <= 1'b1;
			head_q       <= head_n;
			count_q      <= count_n;
			front_q      <= front_n;
			rear_q       <= rear_n;
			fix_front_s1 <= fix_front_n;
			fix_rear_s1  <= fix_rear_n;
		end else if (busy_q) begin
			// fold the read data into the cached end words
			front_q      <= front_cur;
			rear_q       <= rear_cur;
			fix_front_s1 <= 1'b0;
			fix_rear_s1  <= 1'b0;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_n;
			removed_s1 <= removed_n;
		end
	end

	assign res_valid   = busy_q;
	assign res_status  = status_s1;
	assign res_removed = removed_s1;
	assign res_front   = front_cur;
	assign res_rear    = rear_cur;
	assign res_count   = count_q;

endmodule

>>> sv/double_ended_queue_top.sv
// double-ended queue of signed words on a ring of DEPTH entries
// results: a command's result is registered in deq_ctrl and then in the output register before it is offered
// throughput: one command per cycle while the output is not stalled; each command makes at most one memory access
// pops fetch the new end word from the memory in the cycle after acceptance
// reset: asynchronous, clears pointers, count and valid flags; entries are not cleared
// depends on deq_pkg, deq_ctrl and deq_mem
module double_ended_queue_top import deq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int M_DATA_W = ((3 * WORD_W + CNT_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [WORD_W-1:0]   s_tdata,  // value
	input  logic [1:0]          s_tuser,  // command
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // removed_value, front_value, rear_value, occupancy
	output logic [1:0]          m_tuser   // status
);

	logic             res_valid;
	logic             res_take;
	status_t          res_status;
	word_t            res_removed;
	word_t            res_front;
	word_t            res_rear;
	logic [CNT_W-1:0] res_count;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	word_t            mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	word_t            mem_rdata;

	logic             out_valid_q;
	status_t          status_q;
	word_t            removed_q;
	word_t            front_q;
	word_t            rear_q;
	logic [CNT_W-1:0] count_q;
	logic             load;

	deq_ctrl #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (cmd_t'(s_tuser)),
		.in_value   (word_t'(s_tdata)),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res_status (res_status),
		.res_removed(res_removed),
		.res_front  (res_front),
		.res_rear   (res_rear),
		.res_count  (res_count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	deq_mem #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	// output register frees up on the same cycle its transaction completes
	assign res_take = !out_valid_q || m_tready;
	assign load     = res_valid && res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= res_status;
			removed_q <= res_removed;
			front_q   <= res_front;
			rear_q    <= res_rear;
			count_q   <= res_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_DATA_W'({count_q, rear_q, front_q, removed_q});

endmodule
